### sv/mri_pkg.sv
`default_nettype none

package mri_pkg;

  localparam int CUR_W     = 24;
  localparam int SAMP_W    = 16;
  localparam int SUM_W     = 48;
  localparam int FAULT_W   = 32;
  localparam int RES_W     = 32;
  localparam int MS_W      = 14;
  localparam int FRAC_W    = 16;
  localparam int PHASE_W   = 3;
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;

  localparam int SETTLE_MS         = 50;
  localparam int SAMPLE_TIMEOUT_MS = 10000;
  localparam int RAMP_DIVISOR      = 200;
  localparam int TOL_LSB           = 65;

  // reciprocal of the ramp divisor, exact for magnitudes up to 2^23
  localparam int RAMP_SHIFT = 31;
  localparam logic [CUR_W-1:0] RAMP_RECIP =
    CUR_W'(((64'd1 << RAMP_SHIFT) + 64'(RAMP_DIVISOR) - 64'd1) / 64'(RAMP_DIVISOR));

  localparam int DIV_NUM_W = SUM_W + FRAC_W;
  localparam int DIV_DEN_W = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_RAMP     = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SETTLE   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SAMPLE   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_COMPLETE = 3'd4;
  localparam logic [PHASE_W-1:0] PH_FAILED   = 3'd5;

  localparam logic [MODE_W-1:0] MODE_TICK      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POWER_OFF = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BUSY       = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_TARGET = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_CURRENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SAMPLES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_WHEN_DONE = 2'd2;

  typedef struct packed {
    logic cap;
    logic div_start;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_div;
  } dp_status_t;

endpackage

`default_nettype wire

### sv/motor_resistance_identifier.sv
// flow: input captured, then checked, then committed to the result registers; a tick
//   that publishes a resistance also runs the 64-step radix-2 divider before the commit
// a new input is taken only after the previous item commits, and a commit waits while a
//   held result is stalled; the next input is taken while the previous result still waits on out_stall
// reset: synchronous, active low; phase idle, setpoint, resistance and fault cleared
`default_nettype none

module motor_resistance_identifier (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire [mri_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [mri_pkg::CFG_W-1:0]           cfg_wdata,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire [mri_pkg::MODE_W-1:0]          in_mode,
  input  wire [mri_pkg::FAULT_W-1:0]         in_fault_in,
  input  wire [mri_pkg::SAMP_W-1:0]          in_sample_count,
  input  wire signed [mri_pkg::SUM_W-1:0]    in_current_sum,
  input  wire signed [mri_pkg::SUM_W-1:0]    in_voltage_sum,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [mri_pkg::PHASE_W-1:0]        out_phase,
  output logic signed [mri_pkg::CUR_W-1:0]   out_current_setpoint,
  output logic                               out_phase_lock_on,
  output logic                               out_drive_stop,
  output logic                               out_clear_samples,
  output logic signed [mri_pkg::RES_W-1:0]   out_resistance,
  output logic                               out_result_valid,
  output logic [mri_pkg::FAULT_W-1:0]        out_latched_fault,
  output logic [mri_pkg::STATUS_W-1:0]       out_start_status
);
  import mri_pkg::*;

  ctrl_cmd_t            cmd;
  dp_status_t           st;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_quo;

  mri_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .div_done  (div_done),
    .cmd       (cmd)
  );

  mri_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  mri_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .st                   (st),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_mode              (in_mode),
    .in_fault_in          (in_fault_in),
    .in_sample_count      (in_sample_count),
    .in_current_sum       (in_current_sum),
    .in_voltage_sum       (in_voltage_sum),
    .div_num              (div_num),
    .div_den              (div_den),
    .div_quo              (div_quo),
    .out_phase            (out_phase),
    .out_current_setpoint (out_current_setpoint),
    .out_phase_lock_on    (out_phase_lock_on),
    .out_drive_stop       (out_drive_stop),
    .out_clear_samples    (out_clear_samples),
    .out_resistance       (out_resistance),
    .out_result_valid     (out_result_valid),
    .out_latched_fault    (out_latched_fault),
    .out_start_status     (out_start_status)
  );

endmodule

`default_nettype wire

### sv/mri_div.sv
`default_nettype none

module mri_div (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  input  wire [mri_pkg::DIV_NUM_W-1:0]  num,
  input  wire [mri_pkg::DIV_DEN_W-1:0]  den,
  output logic                          done,
  output logic [mri_pkg::DIV_NUM_W-1:0] quo
);
  import mri_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  assign trial = {rem_r, num_r[DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      num_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      num_nxt = {num_r[DIV_NUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

`default_nettype wire

### sv/mri_ctrl.sv
`default_nettype none

module mri_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire                  out_stall,
  input  mri_pkg::dp_status_t  st,
  input  wire                  div_done,
  output mri_pkg::ctrl_cmd_t   cmd
);
  import mri_pkg::*;

  typedef enum logic [3:0] {
    S_WAIT = 4'b0001,
    S_CHK  = 4'b0010,
    S_DIV  = 4'b0100,
    S_UPD  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    unique case (state_r)
      S_WAIT: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (st.needs_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (!out_valid_r || !out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = S_WAIT;
        end
      end
      default: state_nxt = S_WAIT;
    endcase
    out_valid_nxt = cmd.commit ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_WAIT;
  assign out_valid = out_valid_r;

  // result register never overwritten while a stalled result waits
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || !out_stall))
    else $error("commit while output held");

  a_accept_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_CHK))
    else $error("accepted transfer not checked");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider done outside divide state");

  a_drop_on_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(out_valid_r) && $past(rst_n)) |-> $past(!out_stall))
    else $error("result dropped without transfer");

endmodule

`default_nettype wire

### sv/mri_dp.sv
`default_nettype none

module mri_dp (
  input  wire                                clk,
  input  wire                                rst_n,
  input  mri_pkg::ctrl_cmd_t                 cmd,
  output mri_pkg::dp_status_t                st,
  input  wire                                cfg_we,
  input  wire [mri_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [mri_pkg::CFG_W-1:0]           cfg_wdata,
  input  wire [mri_pkg::MODE_W-1:0]          in_mode,
  input  wire [mri_pkg::FAULT_W-1:0]         in_fault_in,
  input  wire [mri_pkg::SAMP_W-1:0]          in_sample_count,
  input  wire signed [mri_pkg::SUM_W-1:0]    in_current_sum,
  input  wire signed [mri_pkg::SUM_W-1:0]    in_voltage_sum,
  output logic [mri_pkg::DIV_NUM_W-1:0]      div_num,
  output logic [mri_pkg::DIV_DEN_W-1:0]      div_den,
  input  wire [mri_pkg::DIV_NUM_W-1:0]       div_quo,
  output logic [mri_pkg::PHASE_W-1:0]        out_phase,
  output logic signed [mri_pkg::CUR_W-1:0]   out_current_setpoint,
  output logic                               out_phase_lock_on,
  output logic                               out_drive_stop,
  output logic                               out_clear_samples,
  output logic signed [mri_pkg::RES_W-1:0]   out_resistance,
  output logic                               out_result_valid,
  output logic [mri_pkg::FAULT_W-1:0]        out_latched_fault,
  output logic [mri_pkg::STATUS_W-1:0]       out_start_status
);
  import mri_pkg::*;

  // configuration
  logic signed [CUR_W-1:0]  tcur_r;
  logic [SAMP_W-1:0]        tsamp_r;
  logic                     swd_r;

  // captured item
  logic [MODE_W-1:0]        mode_r;
  logic [FAULT_W-1:0]       fault_in_r;
  logic [SAMP_W-1:0]        count_r;
  logic signed [SUM_W-1:0]  isum_r;
  logic signed [SUM_W-1:0]  vsum_r;

  // sequencer state
  logic [PHASE_W-1:0]       phase_r, phase_nxt;
  logic [MS_W-1:0]          ms_r, ms_nxt;
  logic signed [CUR_W-1:0]  sp_r, sp_nxt;
  logic                     lock_r, lock_nxt;
  logic signed [RES_W-1:0]  res_r, res_nxt;
  logic                     valid_r, valid_nxt;
  logic [FAULT_W-1:0]       fault_r, fault_nxt;
  logic                     dstop_r, dstop_nxt;
  logic                     clr_r, clr_nxt;
  logic [STATUS_W-1:0]      status_r, status_nxt;

  logic signed [CUR_W:0]    diff0, diff1;
  logic [CUR_W:0]           mag0, mag1;
  logic                     far, done1, pub_cond;
  logic [CUR_W-1:0]         tmag;
  logic [SUM_W-1:0]         vmag, imag;
  logic [2*CUR_W-1:0]       step_prod;
  logic [2*CUR_W-RAMP_SHIFT-1:0] step_q;
  logic [CUR_W-1:0]         step_r, step_nxt;
  logic signed [CUR_W+1:0]  sp_e, tg_e, up_e, dn_e, new_e;
  logic signed [CUR_W-1:0]  sp_step;
  logic [MS_W-1:0]          ms_inc;
  logic signed [RES_W-1:0]  ratio;
  logic                     neg, q_ovf;

  assign diff0 = {sp_r[CUR_W-1], sp_r} - {tcur_r[CUR_W-1], tcur_r};
  assign mag0  = diff0[CUR_W] ? (CUR_W+1)'(-diff0) : diff0;
  assign far   = mag0 > (CUR_W+1)'(TOL_LSB);

  assign pub_cond = (count_r >= tsamp_r) || (ms_r >= MS_W'(SAMPLE_TIMEOUT_MS));

  assign st.needs_div = (mode_r == MODE_TICK) && (phase_r == PH_SAMPLE) && pub_cond;

  assign tmag = tcur_r[CUR_W-1] ? CUR_W'(-tcur_r) : tcur_r;
  assign vmag = vsum_r[SUM_W-1] ? SUM_W'(-vsum_r) : vsum_r;
  assign imag = isum_r[SUM_W-1] ? SUM_W'(-isum_r) : isum_r;

  assign div_num = {vmag, {FRAC_W{1'b0}}};
  assign div_den = imag;

  // ramp step towards the target, reciprocal multiply registered off the target
  assign step_prod = tmag * RAMP_RECIP;
  assign step_q    = step_prod[2*CUR_W-1:RAMP_SHIFT];
  assign step_nxt  = (step_q == '0) ? CUR_W'(1) : CUR_W'(step_q);
  assign sp_e = {{2{sp_r[CUR_W-1]}}, sp_r};
  assign tg_e = {{2{tcur_r[CUR_W-1]}}, tcur_r};
  assign up_e = sp_e + {2'b00, step_r};
  assign dn_e = sp_e - {2'b00, step_r};

  always_comb begin
    if (sp_e < tg_e) begin
      new_e = (up_e < tg_e) ? up_e : tg_e;
    end else if (sp_e > tg_e) begin
      new_e = (dn_e > tg_e) ? dn_e : tg_e;
    end else begin
      new_e = sp_e;
    end
  end

  assign sp_step = new_e[CUR_W-1:0];
  assign diff1   = {sp_step[CUR_W-1], sp_step} - {tcur_r[CUR_W-1], tcur_r};
  assign mag1    = diff1[CUR_W] ? (CUR_W+1)'(-diff1) : diff1;
  assign done1   = mag1 <= (CUR_W+1)'(TOL_LSB);

  assign ms_inc = ms_r + 1'b1;

  // signed, saturated quotient
  assign neg   = vsum_r[SUM_W-1] != isum_r[SUM_W-1];
  assign q_ovf = |div_quo[DIV_NUM_W-1:RES_W-1];

  always_comb begin
    priority if (vsum_r == '0) begin
      ratio = '0;
    end else if (isum_r == '0) begin
      ratio = vsum_r[SUM_W-1] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
    end else if (neg) begin
      ratio = q_ovf ? {1'b1, {(RES_W-1){1'b0}}} : RES_W'(-div_quo[RES_W-1:0]);
    end else begin
      ratio = q_ovf ? {1'b0, {(RES_W-1){1'b1}}} : div_quo[RES_W-1:0];
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    ms_nxt     = ms_r;
    sp_nxt     = sp_r;
    lock_nxt   = lock_r;
    res_nxt    = res_r;
    valid_nxt  = valid_r;
    fault_nxt  = fault_r;
    dstop_nxt  = 1'b0;
    clr_nxt    = 1'b0;
    status_nxt = STAT_OK;
    unique case (mode_r)
      MODE_START: begin
        if (tsamp_r == '0) begin
          status_nxt = STAT_BAD_TARGET;
        end else if (phase_r == PH_RAMP || phase_r == PH_SETTLE ||
                     phase_r == PH_SAMPLE) begin
          status_nxt = STAT_BUSY;
        end else begin
          lock_nxt  = 1'b1;
          fault_nxt = '0;
          valid_nxt = 1'b0;
          ms_nxt    = '0;
          phase_nxt = PH_RAMP;
        end
      end
      MODE_POWER_OFF: begin
        sp_nxt    = '0;
        lock_nxt  = 1'b0;
        dstop_nxt = 1'b1;
        phase_nxt = PH_IDLE;
      end
      MODE_TICK: begin
        if (phase_r == PH_RAMP) begin
          if (!far) begin
            ms_nxt    = '0;
            phase_nxt = PH_SETTLE;
          end else if (fault_in_r != '0) begin
            fault_nxt = fault_in_r;
            valid_nxt = 1'b0;
            phase_nxt = PH_FAILED;
            sp_nxt    = '0;
            lock_nxt  = 1'b0;
            dstop_nxt = 1'b1;
          end else begin
            sp_nxt = sp_step;
            if (done1) begin
              ms_nxt    = '0;
              phase_nxt = PH_SETTLE;
            end
          end
        end else if (phase_r == PH_SETTLE) begin
          ms_nxt = ms_inc;
          if (ms_inc >= MS_W'(SETTLE_MS)) begin
            clr_nxt   = 1'b1;
            ms_nxt    = '0;
            phase_nxt = PH_SAMPLE;
          end
        end else if (phase_r == PH_SAMPLE) begin
          if (pub_cond) begin
            res_nxt   = ratio;
            valid_nxt = count_r != '0;
            phase_nxt = PH_COMPLETE;
            if (swd_r) begin
              sp_nxt    = '0;
              lock_nxt  = 1'b0;
              dstop_nxt = 1'b1;
            end
          end else begin
            ms_nxt = ms_inc;
            if (fault_in_r != '0) begin
              fault_nxt = fault_in_r;
              valid_nxt = 1'b0;
              phase_nxt = PH_FAILED;
              sp_nxt    = '0;
              lock_nxt  = 1'b0;
              dstop_nxt = 1'b1;
            end
          end
        end
      end
      default: begin
        status_nxt = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcur_r   <= '0;
      tsamp_r  <= SAMP_W'(1);
      swd_r    <= 1'b1;
      phase_r  <= PH_IDLE;
      ms_r     <= '0;
      sp_r     <= '0;
      lock_r   <= 1'b0;
      res_r    <= '0;
      valid_r  <= 1'b0;
      fault_r  <= '0;
      dstop_r  <= 1'b0;
      clr_r    <= 1'b0;
      status_r <= STAT_OK;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TARGET_CURRENT: tcur_r  <= cfg_wdata[CUR_W-1:0];
          REG_TARGET_SAMPLES: tsamp_r <= cfg_wdata[SAMP_W-1:0];
          REG_STOP_WHEN_DONE: swd_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        phase_r  <= phase_nxt;
        ms_r     <= ms_nxt;
        sp_r     <= sp_nxt;
        lock_r   <= lock_nxt;
        res_r    <= res_nxt;
        valid_r  <= valid_nxt;
        fault_r  <= fault_nxt;
        dstop_r  <= dstop_nxt;
        clr_r    <= clr_nxt;
        status_r <= status_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    if (cmd.cap) begin
      mode_r     <= in_mode;
      fault_in_r <= in_fault_in;
      count_r    <= in_sample_count;
      isum_r     <= in_current_sum;
      vsum_r     <= in_voltage_sum;
    end
  end

  assign out_phase            = phase_r;
  assign out_current_setpoint = sp_r;
  assign out_phase_lock_on    = lock_r;
  assign out_drive_stop       = dstop_r;
  assign out_clear_samples    = clr_r;
  assign out_resistance       = res_r;
  assign out_result_valid     = valid_r;
  assign out_latched_fault    = fault_r;
  assign out_start_status     = status_r;

endmodule

`default_nettype wire
